/* src/scse_pkg.sv */
package scse_pkg;

  localparam int FREQ_W  = 32;
  localparam int COORD_W = 32;
  localparam int PHASE_W = 32;
  localparam int OFF_W   = 16;
  localparam int AMP_W   = 16;
  localparam int COS_W   = 18;
  localparam int OUT_W   = 32;
  localparam int CFG_W   = 17;

  // Configuration register indexes.
  localparam logic [1:0] REG_COMPONENTS = 2'd0;
  localparam logic [1:0] REG_DIMS       = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;

  // Item actions.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  // Quarter-wave sine polynomial in Q1.30, evaluated by Horner's rule.
  localparam logic signed [32:0] POLY_C9 = 33'sd172272;
  localparam logic signed [32:0] HORNER_C [4] = '{
    -33'sd5026995, 33'sd85569307, -33'sd693598668, 33'sd1686629713
  };
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Travels alongside each component word in the pipeline.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [AMP_W-1:0] amp;
  } tag_t;

endpackage

/* src/scse_phase.sv */
module scse_phase #(
  parameter int MAX_DIMS = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  scse_pkg::tag_t                         tag_in,
  input  logic [MAX_DIMS-1:0][scse_pkg::FREQ_W-1:0]  freq,
  input  logic [MAX_DIMS-1:0][scse_pkg::COORD_W-1:0] coord,
  input  logic [MAX_DIMS-1:0]                    dim_en,
  input  logic [scse_pkg::OFF_W-1:0]             phase_off,
  output scse_pkg::tag_t                         tag_out,
  output logic [scse_pkg::PHASE_W-1:0]           phase
);
  import scse_pkg::*;

  logic signed [63:0] prod [MAX_DIMS];
  logic [MAX_DIMS-1:0][39:0] lowp;
  logic [OFF_W-1:0] off1;
  tag_t tag1;
  logic [39:0] dot;

  // Only bits 39..8 of the dot product reach the phase, so each product keeps 40 bits.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_mul
    assign prod[d] = $signed(freq[d]) * $signed(coord[d]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
    end else begin
      tag1 <= tag_in;
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      lowp[d] <= dim_en[d] ? prod[d][39:0] : 40'd0;
    end
    off1 <= phase_off;
  end

  always_comb begin
    dot = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      dot = dot + lowp[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else begin
      tag_out <= tag1;
    end
    phase <= dot[39:8] + {off1, 16'h0000};
  end

endmodule

/* src/scse_cos.sv */
module scse_cos (
  input  logic                          clk,
  input  logic                          rst,
  input  scse_pkg::tag_t                tag_in,
  input  logic [scse_pkg::PHASE_W-1:0]  phase,
  output scse_pkg::tag_t                tag_out,
  output logic signed [scse_pkg::COS_W-1:0] cos_val
);
  import scse_pkg::*;

  logic [30:0] u_in;
  logic [1:0]  q_in;
  logic [30:0] u2c;

  tag_t        tag0;
  logic [30:0] u0;
  logic [1:0]  q0;
  logic [61:0] uu0;

  tag_t               h_tag  [5];
  logic [30:0]        h_u    [5];
  logic [1:0]         h_q    [5];
  logic [30:0]        h_u2   [5];
  logic signed [64:0] h_prod [5];

  logic signed [33:0] sf, sc, sn, rnd;

  // Quadrants 0 and 2 evaluate the sine at the complement of the residue.
  assign q_in = phase[31:30];
  assign u_in = q_in[0] ? {1'b0, phase[29:0]} : ONE_Q30 - {1'b0, phase[29:0]};
  assign u2c  = uu0[60:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0.vld     <= 1'b0;
      h_tag[0].vld <= 1'b0;
    end else begin
      tag0     <= tag_in;
      h_tag[0] <= tag0;
    end
    u0        <= u_in;
    q0        <= q_in;
    uu0       <= u_in * u_in;
    h_u[0]    <= u0;
    h_q[0]    <= q0;
    h_u2[0]   <= u2c;
    h_prod[0] <= POLY_C9 * $signed({1'b0, u2c});
  end

  // Each step adds the next coefficient and multiplies by u^2; the last one by u.
  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic signed [32:0] s;
    logic [30:0]        m;
    assign s = HORNER_C[k] + 33'(h_prod[k] >>> 30);
    assign m = (k == 3) ? h_u[k] : h_u2[k];
    always_ff @(posedge clk) begin
      if (rst) begin
        h_tag[k+1].vld <= 1'b0;
      end else begin
        h_tag[k+1] <= h_tag[k];
      end
      h_u[k+1]    <= h_u[k];
      h_q[k+1]    <= h_q[k];
      h_u2[k+1]   <= h_u2[k];
      h_prod[k+1] <= s * $signed({1'b0, m});
    end
  end

  always_comb begin
    sf = 34'(h_prod[4] >>> 30);
    if (sf > $signed({3'b000, ONE_Q30})) begin
      sc = $signed({3'b000, ONE_Q30});
    end else if (sf < -$signed({3'b000, ONE_Q30})) begin
      sc = -$signed({3'b000, ONE_Q30});
    end else begin
      sc = sf;
    end
    sn  = (h_q[4][0] ^ h_q[4][1]) ? -sc : sc;
    rnd = sn + 34'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else begin
      tag_out <= h_tag[4];
    end
    cos_val <= COS_W'(rnd >>> 14);
  end

endmodule

/* src/spectral_cosine_sum_evaluator.sv */
// Channel   Handshake                    Payload
// item      item_valid / item_ready      action, component_index, freq_*, phase_offset,
//                                        amplitude, coord_*
// result    result_valid / result_ready  field_value
// config    cfg_we                       cfg_index, cfg_data
//
// A load word writes one component when it is accepted. For a point word, the
// walk reads one component per cycle from the coefficient memories, the read
// register and the 10-stage phase/cosine/weight pipeline drain after it, and the
// S_MUL and S_OUT states scale and round the sum.
// Reset is synchronous and active high; the coefficient memories are not cleared.
// A new word is taken while a finished result still waits for result_ready.
module spectral_cosine_sum_evaluator #(
  parameter int MAX_COMPONENTS = 256,
  parameter int MAX_DIMS       = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              action,
  input  logic [7:0]                        component_index,
  input  logic signed [scse_pkg::FREQ_W-1:0]  freq_x,
  input  logic signed [scse_pkg::FREQ_W-1:0]  freq_y,
  input  logic signed [scse_pkg::FREQ_W-1:0]  freq_z,
  input  logic [scse_pkg::OFF_W-1:0]        phase_offset,
  input  logic [scse_pkg::AMP_W-1:0]        amplitude,
  input  logic signed [scse_pkg::COORD_W-1:0] coord_x,
  input  logic signed [scse_pkg::COORD_W-1:0] coord_y,
  input  logic signed [scse_pkg::COORD_W-1:0] coord_z,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [scse_pkg::OUT_W-1:0] field_value,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [scse_pkg::CFG_W-1:0]        cfg_data
);
  import scse_pkg::*;

  localparam int IDX_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int NC_W   = $clog2(MAX_COMPONENTS + 1);
  localparam int PROD_W = AMP_W + 1 + COS_W;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int HI_W   = ACC_W - 24;
  localparam int PHI_W  = HI_W + CFG_W + 1;
  localparam int V_W    = PHI_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_MUL, S_OUT} state_t;

  state_t state;

  // Configuration registers.
  logic [8:0]       comp_cfg;
  logic [1:0]       dims_cfg;
  logic [CFG_W-1:0] scale_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cfg  <= 9'd1;
      dims_cfg  <= 2'd2;
      scale_cfg <= 17'd92682;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMPONENTS: comp_cfg  <= cfg_data[8:0];
        REG_DIMS:       dims_cfg  <= cfg_data[1:0];
        REG_SCALE:      scale_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word decode.
  logic [2:0][FREQ_W-1:0]  freq_all;
  logic [2:0][COORD_W-1:0] coord_all;
  logic                    accept, load_we, point_go;
  logic [IDX_W-1:0]        load_addr;
  logic [NC_W-1:0]         ncomp_in;

  assign freq_all   = {freq_z, freq_y, freq_x};
  assign coord_all  = {coord_z, coord_y, coord_x};
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid & item_ready;
  assign load_we    = accept & (action == ACT_LOAD) & (32'(component_index) < MAX_COMPONENTS);
  assign point_go   = accept & (action == ACT_POINT);
  assign load_addr  = IDX_W'(component_index);
  assign ncomp_in   = (32'(comp_cfg) > MAX_COMPONENTS) ? NC_W'(MAX_COMPONENTS)
                                                       : NC_W'(comp_cfg);

  // Component walk.
  logic [IDX_W-1:0] idx;
  logic [NC_W-1:0]  ncomp_r;
  logic             issue, issue_last;

  assign issue      = (state == S_WALK);
  assign issue_last = (NC_W'(idx) + NC_W'(1)) == ncomp_r;

  // Coefficient memories: one frequency word per axis, and phase with amplitude.
  // Reads are registered, so the data follows the walk address in the next cycle.
  logic [MAX_DIMS-1:0][FREQ_W-1:0] rd_freq;
  logic [OFF_W+AMP_W-1:0]          pamem [MAX_COMPONENTS];
  logic [OFF_W+AMP_W-1:0]          rd_pa;
  logic                            rd_vld, rd_last;
  tag_t                            tag_rd;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_fmem
    logic [FREQ_W-1:0] fmem [MAX_COMPONENTS];
    always_ff @(posedge clk) begin
      if (load_we) begin
        fmem[load_addr] <= freq_all[d];
      end
      if (issue) begin
        rd_freq[d] <= fmem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      pamem[load_addr] <= {phase_offset, amplitude};
    end
    if (issue) begin
      rd_pa <= pamem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
    rd_last <= issue_last;
  end

  assign tag_rd = '{vld: rd_vld, last: rd_last, amp: rd_pa[AMP_W-1:0]};

  // Point coordinates and the axes that take part.
  logic [MAX_DIMS-1:0][COORD_W-1:0] coord_r;
  logic [MAX_DIMS-1:0]              dim_en;

  always_ff @(posedge clk) begin
    if (point_go) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord_r[d] <= coord_all[d];
        dim_en[d]  <= 2'(d) < dims_cfg;
      end
    end
  end

  // Phase and cosine pipeline.
  tag_t                      ph_tag, cos_tag, amp_tag;
  logic [PHASE_W-1:0]        phase;
  logic signed [COS_W-1:0]   cos_val;
  logic signed [PROD_W-1:0]  amp_prod;

  scse_phase #(.MAX_DIMS(MAX_DIMS)) u_phase (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag_rd),
    .freq      (rd_freq),
    .coord     (coord_r),
    .dim_en    (dim_en),
    .phase_off (rd_pa[OFF_W+AMP_W-1:AMP_W]),
    .tag_out   (ph_tag),
    .phase     (phase)
  );

  scse_cos u_cos (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (ph_tag),
    .phase   (phase),
    .tag_out (cos_tag),
    .cos_val (cos_val)
  );

  // Weight each cosine by its amplitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      amp_tag.vld <= 1'b0;
    end else begin
      amp_tag <= cos_tag;
    end
    amp_prod <= $signed({1'b0, cos_tag.amp}) * cos_val;
  end

  // Final scaling: the accumulator is split at bit 24 so that each partial
  // product stays narrow. The rounding constant only reaches the low half,
  // whose carry then joins the high product.
  logic signed [ACC_W-1:0] acc;
  logic [40:0]             p_lo;
  logic signed [PHI_W-1:0] p_hi;
  logic [41:0]             lo_rnd;
  logic signed [V_W-1:0]   v;
  logic signed [63:0]      v64;
  logic signed [OUT_W-1:0] sat;

  always_comb begin
    lo_rnd = {1'b0, p_lo} + 42'h80_0000;
    v      = V_W'(p_hi) + V_W'($signed({1'b0, lo_rnd[41:24]}));
    v64    = 64'(v);
    if (v64 > 64'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (v64 < -64'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = OUT_W'(v64);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (amp_tag.vld) begin
        acc <= acc + ACC_W'(amp_prod);
      end
      unique case (state)
        S_IDLE: begin
          if (point_go) begin
            acc     <= '0;
            idx     <= '0;
            ncomp_r <= ncomp_in;
            state   <= (ncomp_in == '0) ? S_MUL : S_WALK;
          end
        end
        S_WALK: begin
          idx <= idx + IDX_W'(1);
          if (issue_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The last weighted term enters the sum on this edge.
          if (amp_tag.vld && amp_tag.last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_lo  <= acc[23:0] * scale_cfg;
          p_hi  <= $signed(acc[ACC_W-1:24]) * $signed({1'b0, scale_cfg});
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            field_value  <= sat;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Weighted terms only reach the sum while a point is being walked or drained.
  a_term_in_walk: assert property (@(posedge clk) disable iff (rst)
    amp_tag.vld |-> (state == S_WALK || state == S_DRAIN))
    else $error("weighted term outside a point walk");

  // The final component of a walk hands over to the drain.
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (state == S_DRAIN))
    else $error("walk did not end at the last component");

  // Memory read data is valid only in the cycle after a walk address.
  a_read_follows_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == S_WALK))
    else $error("memory read without walk address");

  // A point with components starts a walk.
  a_point_walks: assert property (@(posedge clk) disable iff (rst)
    (point_go && ncomp_in != '0) |=> (state == S_WALK))
    else $error("point did not start a walk");

endmodule
